/* rtl/core/fyd_pkg.sv */
// Shared constants and types for the card dealer: store size, derived widths,
// generator constants and command codes. No dependencies.
`default_nettype none
package fyd_pkg;

  localparam int STORE_ENTRIES = 52;
  localparam int IDX_W   = $clog2(STORE_ENTRIES);
  localparam int POS_W   = $clog2(STORE_ENTRIES + 1);
  localparam int ENTRY_W = 6;
  localparam int REM_W   = 6;
  localparam int SEED_W  = 32;

  localparam logic [31:0] LCG_MUL    = 32'd1664525;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;
  localparam int          DRAW_W     = 15;
  localparam int          DRAW_SHIFT = 16;
  localparam int          DCNT_W     = $clog2(DRAW_W);

  typedef enum logic [1:0] {
    FUNC_DEAL    = 2'd0,
    FUNC_SHUFFLE = 2'd1,
    FUNC_RESTORE = 2'd2,
    FUNC_RESEED  = 2'd3
  } func_t;

endpackage
`default_nettype wire

/* rtl/core/fyd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fyd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/core/fyd_modu.sv */
// Bit-serial remainder unit: 15-bit draw modulo a divisor of up to POS_W bits,
// one dividend bit per cycle. Depends on fyd_pkg.
`default_nettype none
module fyd_modu (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [fyd_pkg::DRAW_W-1:0]  dividend,
  input  wire logic [fyd_pkg::POS_W-1:0]   divisor,
  output logic                             done,
  output logic      [fyd_pkg::POS_W-1:0]   remainder
);

  logic [fyd_pkg::POS_W-1:0]  rem_r, rem_nxt;
  logic [fyd_pkg::POS_W-1:0]  div_r;
  logic [fyd_pkg::DRAW_W-1:0] dvd_r;
  logic [fyd_pkg::DCNT_W-1:0] cnt_r;
  logic                       run_r;
  logic                       done_r;
  logic [fyd_pkg::POS_W:0]    trial;

  // restoring step: shift in next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_r, dvd_r[fyd_pkg::DRAW_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = fyd_pkg::POS_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[fyd_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= '0;
        div_r <= divisor;
        dvd_r <= dividend;
        cnt_r <= fyd_pkg::DCNT_W'(fyd_pkg::DRAW_W - 1);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[fyd_pkg::DRAW_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

/* rtl/core/lcg_fisher_yates_dealer_top.sv */
// Card dealer: entry store in RAM, deal position, LCG and Fisher-Yates sequencer.
// Depends on fyd_pkg, fyd_ram and fyd_modu.
//
// Usage: drive in_func/in_seed_value with start; the item is taken on an edge
// where start is high and busy is low. Exactly one result follows per item, on
// out_entry/out_reshuffled/out_remaining for a single cycle with out_strobe
// high; there is no back-pressure, so the receiver must take it then.
// Reseed and restore register their result at the accepting edge and leave
// busy low; a deal holds busy through an address state, then a RAM read-data
// state, and registers its result as it returns to idle. A shuffle walks
// i = 51 down to 1; each step makes one draw, starts the remainder, waits on
// the bit-serial remainder and then makes the four RAM accesses of the swap
// (two reads, two writes).
// A deal on an exhausted store runs that shuffle first and sets out_reshuffled.
// Reset and restore put the store in identity order at once through per-entry
// valid bits (an entry not yet written reads as its own index); no sweep.
`default_nettype none
module lcg_fisher_yates_dealer_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_func,
  input  wire logic [fyd_pkg::SEED_W-1:0]    in_seed_value,
  output logic                               out_strobe,
  output logic      [fyd_pkg::ENTRY_W-1:0]   out_entry,
  output logic                               out_reshuffled,
  output logic      [fyd_pkg::REM_W-1:0]     out_remaining
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEAL_RD,
    ST_DEAL_WAIT,
    ST_SH_DRAW,
    ST_SH_MOD_GO,
    ST_SH_MOD_WAIT,
    ST_SH_RD_I,
    ST_SH_RD_J,
    ST_SH_WR_I,
    ST_SH_WR_J
  } state_t;

  state_t                          state_r;
  logic [fyd_pkg::POS_W-1:0]       pos_r;
  logic [31:0]                     gen_r;
  logic [fyd_pkg::IDX_W-1:0]       i_r;
  logic [fyd_pkg::IDX_W-1:0]       j_r;
  logic [fyd_pkg::ENTRY_W-1:0]     a_r;      // entry i held during swap
  logic                            resh_r;   // shuffle was forced by a deal
  logic [fyd_pkg::STORE_ENTRIES-1:0] valid_r;
  logic [fyd_pkg::IDX_W-1:0]       rd_addr_r;
  logic                            rd_valid_r;

  logic                            out_strobe_r;
  logic [fyd_pkg::ENTRY_W-1:0]     out_entry_r;
  logic                            out_resh_r;
  logic [fyd_pkg::REM_W-1:0]       out_rem_r;

  logic [fyd_pkg::IDX_W-1:0]       raddr;
  logic [fyd_pkg::ENTRY_W-1:0]     rdata;
  logic [fyd_pkg::ENTRY_W-1:0]     rd_val;
  logic                            we;
  logic [fyd_pkg::IDX_W-1:0]       waddr;
  logic [fyd_pkg::ENTRY_W-1:0]     wdata;
  logic                            mod_start;
  logic                            mod_done;
  logic [fyd_pkg::POS_W-1:0]       mod_rem;
  logic [15:0]                     left_after_deal;
  fyd_pkg::func_t                  func;

  assign func = fyd_pkg::func_t'(in_func);

  // read address per state
  always_comb begin
    case (state_r)
      ST_DEAL_RD: raddr = pos_r[fyd_pkg::IDX_W-1:0];
      ST_SH_RD_J: raddr = j_r;
      default:    raddr = i_r;
    endcase
  end

  // swap write-back: entry j goes to i, held entry i goes to j
  always_comb begin
    we    = (state_r == ST_SH_WR_I) || (state_r == ST_SH_WR_J);
    waddr = (state_r == ST_SH_WR_I) ? i_r : j_r;
    wdata = (state_r == ST_SH_WR_I) ? rd_val : a_r;
  end

  // never-written entries read as their own index
  assign rd_val    = rd_valid_r ? rdata : fyd_pkg::ENTRY_W'(rd_addr_r);
  assign mod_start = (state_r == ST_SH_MOD_GO);

  // entries left once the deal completes
  assign left_after_deal = 16'(fyd_pkg::STORE_ENTRIES) - 16'(pos_r) - 16'd1;

  fyd_ram #(
    .WIDTH (fyd_pkg::ENTRY_W),
    .DEPTH (fyd_pkg::STORE_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  fyd_modu u_modu (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (gen_r[fyd_pkg::DRAW_SHIFT +: fyd_pkg::DRAW_W]),
    .divisor   (fyd_pkg::POS_W'(i_r) + fyd_pkg::POS_W'(1)),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    rd_addr_r  <= raddr;
    rd_valid_r <= valid_r[raddr];
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      gen_r        <= 32'd1;
      valid_r      <= '0;
      resh_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            unique case (func)
              fyd_pkg::FUNC_DEAL: begin
                if (pos_r == fyd_pkg::POS_W'(fyd_pkg::STORE_ENTRIES)) begin
                  resh_r  <= 1'b1;
                  i_r     <= fyd_pkg::IDX_W'(fyd_pkg::STORE_ENTRIES - 1);
                  state_r <= ST_SH_DRAW;
                end else begin
                  resh_r  <= 1'b0;
                  state_r <= ST_DEAL_RD;
                end
              end
              fyd_pkg::FUNC_SHUFFLE: begin
                resh_r  <= 1'b0;
                i_r     <= fyd_pkg::IDX_W'(fyd_pkg::STORE_ENTRIES - 1);
                state_r <= ST_SH_DRAW;
              end
              fyd_pkg::FUNC_RESTORE: begin
                valid_r      <= '0;
                pos_r        <= '0;
                out_strobe_r <= 1'b1;
                out_entry_r  <= '0;
                out_resh_r   <= 1'b0;
                out_rem_r    <= fyd_pkg::REM_W'(fyd_pkg::STORE_ENTRIES);
              end
              fyd_pkg::FUNC_RESEED: begin
                gen_r        <= in_seed_value;
                out_strobe_r <= 1'b1;
                out_entry_r  <= '0;
                out_resh_r   <= 1'b0;
                out_rem_r    <= fyd_pkg::REM_W'(16'(fyd_pkg::STORE_ENTRIES)
                                                - 16'(pos_r));
              end
            endcase
          end
        end
        ST_DEAL_RD: begin
          state_r <= ST_DEAL_WAIT;
        end
        ST_DEAL_WAIT: begin
          pos_r        <= pos_r + 1'b1;
          out_strobe_r <= 1'b1;
          out_entry_r  <= rd_val;
          out_resh_r   <= resh_r;
          out_rem_r    <= left_after_deal[fyd_pkg::REM_W-1:0];
          state_r      <= ST_IDLE;
        end
        ST_SH_DRAW: begin
          gen_r   <= gen_r * fyd_pkg::LCG_MUL + fyd_pkg::LCG_ADD;
          state_r <= ST_SH_MOD_GO;
        end
        ST_SH_MOD_GO: begin
          state_r <= ST_SH_MOD_WAIT;
        end
        ST_SH_MOD_WAIT: begin
          if (mod_done) begin
            j_r     <= mod_rem[fyd_pkg::IDX_W-1:0];
            state_r <= ST_SH_RD_I;
          end
        end
        ST_SH_RD_I: begin
          state_r <= ST_SH_RD_J;
        end
        ST_SH_RD_J: begin
          a_r     <= rd_val;
          state_r <= ST_SH_WR_I;
        end
        ST_SH_WR_I: begin
          valid_r[i_r] <= 1'b1;
          state_r      <= ST_SH_WR_J;
        end
        ST_SH_WR_J: begin
          valid_r[j_r] <= 1'b1;
          if (i_r == fyd_pkg::IDX_W'(1)) begin
            pos_r <= '0;
            if (resh_r) begin
              state_r <= ST_DEAL_RD;
            end else begin
              out_strobe_r <= 1'b1;
              out_entry_r  <= '0;
              out_resh_r   <= 1'b0;
              out_rem_r    <= fyd_pkg::REM_W'(fyd_pkg::STORE_ENTRIES);
              state_r      <= ST_IDLE;
            end
          end else begin
            i_r     <= i_r - 1'b1;
            state_r <= ST_SH_DRAW;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_entry      = out_entry_r;
  assign out_reshuffled = out_resh_r;
  assign out_remaining  = out_rem_r;

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the card dealer: a directed table of commands, then random
// command sequences, scored against typed-in results or an in-bench deck model.
// Depends on fyd_pkg and lcg_fisher_yates_dealer_top.
`default_nettype none
module testbench;

  // one result as it appears on the out_ ports
  typedef struct packed {
    logic [fyd_pkg::ENTRY_W-1:0] entry;
    logic                        reshuffled;
    logic [fyd_pkg::REM_W-1:0]   remaining;
  } deal_res_t;

  // directed row: command, seed, and a typed-in result where it is obvious
  typedef struct {
    fyd_pkg::func_t cmd;
    logic [31:0]    seed;
    bit             typed;
    deal_res_t      res;
  } cmd_row_t;

  localparam int DIR_ROWS     = 20;
  localparam int RANDOM_ITEMS = 360;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [1:0]                   in_func;
  logic [fyd_pkg::SEED_W-1:0]   in_seed_value;
  logic                         out_strobe;
  logic [fyd_pkg::ENTRY_W-1:0]  out_entry;
  logic                         out_reshuffled;
  logic [fyd_pkg::REM_W-1:0]    out_remaining;

  // deck model state
  logic [fyd_pkg::ENTRY_W-1:0]  deck [fyd_pkg::STORE_ENTRIES];
  int                           deck_pos;
  logic [31:0]                  lcg_state;

  deal_res_t           pending_results [$];
  int                  mismatch_count = 0;
  int                  items_sent = 0;
  bit                  idle_en = 1'b0;
  cmd_row_t            dir_tab [DIR_ROWS];

  lcg_fisher_yates_dealer_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_seed_value  (in_seed_value),
    .out_strobe     (out_strobe),
    .out_entry      (out_entry),
    .out_reshuffled (out_reshuffled),
    .out_remaining  (out_remaining)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Deck model
  // ---------------------------------------------------------------------------

  // advance the generator; the draw is bits 30..16 of the new state
  function automatic logic [fyd_pkg::DRAW_W-1:0] lcg_draw15();
    lcg_state = lcg_state * fyd_pkg::LCG_MUL + fyd_pkg::LCG_ADD;
    return lcg_state[fyd_pkg::DRAW_SHIFT +: fyd_pkg::DRAW_W];
  endfunction

  function automatic void deck_restore();
    for (int k = 0; k < fyd_pkg::STORE_ENTRIES; k++) deck[k] = fyd_pkg::ENTRY_W'(k);
    deck_pos = 0;
  endfunction

  // Fisher-Yates, top entry down; plain remainder, so modulo bias is kept
  function automatic void deck_shuffle();
    int                          j;
    logic [fyd_pkg::ENTRY_W-1:0] t;
    for (int i = fyd_pkg::STORE_ENTRIES - 1; i > 0; i--) begin
      j       = int'(lcg_draw15()) % (i + 1);
      t       = deck[i];
      deck[i] = deck[j];
      deck[j] = t;
    end
    deck_pos = 0;
  endfunction

  function automatic deal_res_t deck_command(fyd_pkg::func_t cmd, logic [31:0] seed);
    deal_res_t r;
    r = '0;
    case (cmd)
      fyd_pkg::FUNC_DEAL: begin
        // exhausted deck: reshuffle first, then deal from the top
        if (deck_pos >= fyd_pkg::STORE_ENTRIES) begin
          deck_shuffle();
          r.reshuffled = 1'b1;
        end
        r.entry  = deck[deck_pos];
        deck_pos = deck_pos + 1;
      end
      fyd_pkg::FUNC_SHUFFLE: deck_shuffle();
      fyd_pkg::FUNC_RESTORE: deck_restore();
      default:               lcg_state = seed;
    endcase
    r.remaining = fyd_pkg::REM_W'(fyd_pkg::STORE_ENTRIES - deck_pos);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver
  // ---------------------------------------------------------------------------

  // Called at a rising edge; returns at the rising edge that takes the item.
  // busy is looked at on the falling edge, where it is settled for the next
  // rising edge. start stays high into the next item unless a gap is drawn.
  task automatic send_cmd(input fyd_pkg::func_t cmd, input logic [31:0] seed,
                          input bit typed, input deal_res_t typed_res);
    deal_res_t predicted;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start         <= 1'b1;
    in_func       <= cmd;
    in_seed_value <= seed;
    do @(negedge clk); while (busy);
    // item goes in at the coming edge; model moves on regardless of typed rows
    predicted = deck_command(cmd, seed);
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
    @(posedge clk);
  endtask

  task automatic deal_run(input int n);
    repeat (n) send_cmd(fyd_pkg::FUNC_DEAL, $urandom(), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: strobe and fields sampled mid-cycle
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    deal_res_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result entry %0d reshuffled %0d remaining %0d",
                 $time, out_entry, out_reshuffled, out_remaining);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_entry !== want.entry) begin
          $display("%0t: entry expected %0d got %0d", $time, want.entry, out_entry);
          mismatch_count++;
        end
        if (out_reshuffled !== want.reshuffled) begin
          $display("%0t: reshuffled expected %0d got %0d",
                   $time, want.reshuffled, out_reshuffled);
          mismatch_count++;
        end
        if (out_remaining !== want.remaining) begin
          $display("%0t: remaining expected %0d got %0d",
                   $time, want.remaining, out_remaining);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int kind;
    int total;

    rst_n         = 1'b0;
    start         = 1'b0;
    in_func       = fyd_pkg::FUNC_DEAL;
    in_seed_value = '0;
    lcg_state     = 32'd1;
    deck_restore();

    // typed results: fresh deck, reseed and restore leave the position alone
    // or rewind it, a shuffle rewinds it; model-checked rows are left untyped
    dir_tab = '{
      '{fyd_pkg::FUNC_DEAL,    32'h0000_0000, 1'b1, '{6'd0, 1'b0, 6'd51}},
      '{fyd_pkg::FUNC_DEAL,    32'hFFFF_FFFF, 1'b1, '{6'd1, 1'b0, 6'd50}},
      '{fyd_pkg::FUNC_RESEED,  32'h0000_0000, 1'b1, '{6'd0, 1'b0, 6'd50}},
      '{fyd_pkg::FUNC_RESEED,  32'hFFFF_FFFF, 1'b1, '{6'd0, 1'b0, 6'd50}},
      '{fyd_pkg::FUNC_RESTORE, 32'hFFFF_FFFF, 1'b1, '{6'd0, 1'b0, 6'd52}},
      '{fyd_pkg::FUNC_DEAL,    32'h0000_0000, 1'b1, '{6'd0, 1'b0, 6'd51}},
      '{fyd_pkg::FUNC_SHUFFLE, 32'hFFFF_FFFF, 1'b1, '{6'd0, 1'b0, 6'd52}},
      '{fyd_pkg::FUNC_DEAL,    32'h0000_0000, 1'b0, '0},
      '{fyd_pkg::FUNC_DEAL,    32'hFFFF_FFFF, 1'b0, '0},
      '{fyd_pkg::FUNC_RESEED,  32'h0000_0000, 1'b1, '{6'd0, 1'b0, 6'd50}},
      '{fyd_pkg::FUNC_SHUFFLE, 32'h0000_0000, 1'b1, '{6'd0, 1'b0, 6'd52}},
      '{fyd_pkg::FUNC_DEAL,    32'h0000_0000, 1'b0, '0},
      '{fyd_pkg::FUNC_RESEED,  32'hAAAA_5555, 1'b1, '{6'd0, 1'b0, 6'd51}},
      '{fyd_pkg::FUNC_SHUFFLE, 32'h0000_0000, 1'b1, '{6'd0, 1'b0, 6'd52}},
      '{fyd_pkg::FUNC_DEAL,    32'h0000_0000, 1'b0, '0},
      '{fyd_pkg::FUNC_SHUFFLE, 32'h0000_0000, 1'b1, '{6'd0, 1'b0, 6'd52}},
      '{fyd_pkg::FUNC_DEAL,    32'h0000_0000, 1'b0, '0},
      '{fyd_pkg::FUNC_RESTORE, 32'h0000_0000, 1'b1, '{6'd0, 1'b0, 6'd52}},
      '{fyd_pkg::FUNC_RESEED,  32'h55AA_AA55, 1'b1, '{6'd0, 1'b0, 6'd52}},
      '{fyd_pkg::FUNC_DEAL,    32'h0000_0000, 1'b1, '{6'd0, 1'b0, 6'd51}}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, back to back
    foreach (dir_tab[r])
      send_cmd(dir_tab[r].cmd, dir_tab[r].seed, dir_tab[r].typed, dir_tab[r].res);

    // random part in episodes; long deal runs walk off the end of the deck,
    // so the exhausted-deck reshuffle is hit many times
    total = items_sent + RANDOM_ITEMS;
    while (items_sent < total) begin
      // no idling over the closing stretch
      idle_en = (items_sent < total - 60) && ($urandom_range(0, 2) != 0);
      kind    = $urandom_range(0, 9);
      if (kind <= 4) begin
        // well formed: maybe reseed, shuffle or restore, then deal
        if ($urandom_range(0, 1))
          send_cmd(fyd_pkg::FUNC_RESEED, $urandom(), 1'b0, '0);
        if ($urandom_range(0, 3) == 0)
          send_cmd(fyd_pkg::FUNC_RESTORE, $urandom(), 1'b0, '0);
        else
          send_cmd(fyd_pkg::FUNC_SHUFFLE, $urandom(), 1'b0, '0);
        deal_run($urandom_range(1, 60));
      end else if (kind <= 7) begin
        deal_run($urandom_range(1, 30));
      end else if (kind == 8) begin
        // noise: any command, any seed
        send_cmd(fyd_pkg::func_t'($urandom_range(0, 3)), $urandom(), 1'b0, '0);
      end else begin
        // identity deck dealt right through and past its end
        send_cmd(fyd_pkg::FUNC_RESTORE, $urandom(), 1'b0, '0);
        deal_run($urandom_range(fyd_pkg::STORE_ENTRIES + 1, fyd_pkg::STORE_ENTRIES + 4));
      end
    end

    start <= 1'b0;
    // drain; a trailing shuffle can still be running
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run (every item a full shuffle)
  initial begin
    #25_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/core/fyd_pkg.sv
rtl/core/fyd_ram.sv
rtl/core/fyd_modu.sv
rtl/core/lcg_fisher_yates_dealer_top.sv
bench/testbench.sv
